// File: rtl/core/lcg_pkg.sv
// Shared constants, register codes and cosine table builder for the chirp generator.
package lcg_pkg;

	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int INC_W       = 32;
	localparam int SWEEP_LEN_W = 17;
	localparam int TV_W        = 15;

	localparam logic [INC_W-1:0]       START_INC_RST = 32'd42949673;
	localparam logic [INC_W-1:0]       END_INC_RST   = 32'd429496730;
	localparam logic [SWEEP_LEN_W-1:0] SWEEP_LEN_RST = 17'd1024;
	localparam int                     AMPLITUDE_RST = 16384;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_START_INC,
		REG_END_INC,
		REG_SWEEP_LEN,
		REG_AMPLITUDE
	} cfg_reg_t;

	// pi/2 in Q.60
	localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

	// Taylor denominators (2n+1)(2n+2) for n = 0..9
	localparam logic [63:0] TAYLOR_DIV [0:9] = '{
		64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
		64'd132, 64'd182, 64'd240, 64'd306, 64'd380
	};

	// 32767*cos(pi/2 * k / 2^tb), evaluated at elaboration in Q2.30.
	function automatic logic [TV_W-1:0] cos_entry(input int unsigned k, input int unsigned tb);
		logic [63:0]        lo;
		logic [63:0]        x60;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] acc;
		logic [63:0]        r;
		int unsigned        n;
		lo   = HALF_PI_Q60 & ((64'd1 << tb) - 64'd1);
		x60  = (HALF_PI_Q60 >> tb) * 64'(k) + ((lo * 64'(k)) >> tb);
		x    = x60 >> 30;
		x2   = (x * x) >> 30;
		term = 64'd1 << 30;
		acc  = $signed(term);
		for (n = 0; n < 10; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n];
			if (n[0] == 1'b0) begin
				acc = acc - $signed(term);
			end else begin
				acc = acc + $signed(term);
			end
		end
		if (acc < 0) begin
			acc = '0;
		end
		if (acc > $signed(64'd1 << 30)) begin
			acc = $signed(64'd1 << 30);
		end
		r = ($unsigned(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
		return r[TV_W-1:0];
	endfunction

endpackage

// File: rtl/core/linear_chirp_generator_core.sv
// Linear chirp generator: iterative increment interpolation and quarter-wave cosine output.
//
// Usage
//   Input channel (in_valid/in_ready, restart): each transfer asks for one cosine
//   sample. restart=1 throws away the running sweep and returns sample zero.
//   Output channel (out_valid/out_ready, sample, last): one transfer per input
//   transfer, in order; last marks the final sample of a sweep.
//   Config port (cfg_write, cfg_index, cfg_data): 0 start increment, 1 end increment,
//   2 sweep length (clamped to 2..MAX_SWEEP), 3 amplitude. Write only while idle.
// Timing
//   An item goes through these steps in order: accept, one multiply of |end-start|
//   by the sample index, the restoring divider (PHASE_BITS quotient bits, one quotient
//   bit per cycle), one scale multiply and a final round into the output register.
//   The block takes no new item while one is in flight;
//   in_ready stays low until the result loads.
// Reset
//   arst_n clears the sweep state (next item starts a sweep) and loads the default
//   register values. The cosine table is a constant ROM, so no fill time is needed.
// Stall
//   A finished sample waits in the output register; if out_ready is low, the block
//   holds the next result in its final step until the register frees up.
module linear_chirp_generator_core #(
	parameter int PHASE_BITS  = 32,
	parameter int TABLE_BITS  = 10,
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_SWEEP   = 65536
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [lcg_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [lcg_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              restart,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [SAMPLE_BITS-1:0]     sample,
	output logic                              last
);
	import lcg_pkg::*;

	localparam int PB      = PHASE_BITS;
	localparam int TB      = TABLE_BITS;
	localparam int SB      = SAMPLE_BITS;
	localparam int AMP_W   = SB - 1;
	localparam int IB      = (MAX_SWEEP > 2) ? $clog2(MAX_SWEEP) : 1;
	localparam int NW      = (IB + 1 > SWEEP_LEN_W) ? IB + 1 : SWEEP_LEN_W;
	localparam int QUARTER = 1 << TB;
	localparam int MA      = (PB > AMP_W) ? PB : AMP_W;
	localparam int MB      = (IB > TV_W) ? IB : TV_W;
	localparam int SCL_W   = AMP_W + TV_W;
	localparam int CW      = (PB > 1) ? $clog2(PB) : 1;

	typedef logic [TV_W-1:0] rom_t [0:QUARTER];

	function automatic rom_t build_rom();
		rom_t        r;
		int unsigned k;
		for (k = 0; k <= QUARTER; k++) begin
			r[k] = cos_entry(k, TB);
		end
		return r;
	endfunction

	localparam rom_t COS_ROM = build_rom();

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_SCALE,
		S_OUT
	} state_t;

	// configuration registers
	logic [INC_W-1:0]       start_inc_q;
	logic [INC_W-1:0]       end_inc_q;
	logic [SWEEP_LEN_W-1:0] sweep_len_q;
	logic [AMP_W-1:0]       amp_q;

	// sweep state and sequencer
	state_t              state_q;
	logic [PB-1:0]       phase_q;
	logic [IB-1:0]       idx_q;
	logic [PB-1:0]       prev_inc_q;
	logic [IB-1:0]       m_q;
	logic [IB-1:0]       i_q;
	logic [PB-1:0]       d_q;
	logic                up_q;
	logic                last_flag_q;
	logic [IB-1:0]       rem_q;
	logic [PB-1:0]       quo_q;
	logic [CW-1:0]       cnt_q;
	logic [SCL_W-1:0]    scl_q;
	logic [TV_W-1:0]     tv_q;
	logic                out_valid_q;
	logic signed [SB-1:0] sample_q;
	logic                last_q;

	// combinational
	logic [NW-1:0]       n_ext;
	logic [NW-1:0]       n_cl;
	logic [NW-1:0]       m_full;
	logic [IB-1:0]       m_w;
	logic                start_sweep;
	logic [IB-1:0]       idx_cur;
	logic                is_last;
	logic [PB-1:0]       s_inc;
	logic [PB-1:0]       e_inc;
	logic [TB+1:0]       top;
	logic [1:0]          quad;
	logic [TB:0]         rom_addr;
	logic [MA-1:0]       mul_a;
	logic [MB-1:0]       mul_b;
	logic [MA+MB-1:0]    prod;
	logic [IB:0]         trial;
	logic                div_ge;
	logic [IB:0]         trial_sub;
	logic [IB-1:0]       rem_nx;
	logic [SCL_W-1:0]    rnd;
	logic [AMP_W-1:0]    mag;
	logic                accept;
	logic                load_out;

	assign accept = in_valid && in_ready;

	// final step may load the output register once it is empty or being drained
	assign load_out = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// sweep length clamp, then m = N - 1
	assign n_ext  = NW'(sweep_len_q);
	assign n_cl   = (n_ext < NW'(2)) ? NW'(2) :
	                (n_ext > NW'(MAX_SWEEP)) ? NW'(MAX_SWEEP) : n_ext;
	assign m_full = n_cl - NW'(1);
	assign m_w    = m_full[IB-1:0];

	assign start_sweep = restart || (idx_q == '0);
	assign idx_cur     = start_sweep ? '0 : idx_q;
	assign is_last     = (idx_cur >= m_w);

	assign s_inc = PB'(start_inc_q);
	assign e_inc = PB'(end_inc_q);

	// phase to quadrant and table address (q1/q3 mirror the index)
	assign top      = phase_q[PB-1 -: TB+2];
	assign quad     = top[TB+1:TB];
	assign rom_addr = quad[0] ? ((TB+1)'(QUARTER) - {1'b0, top[TB-1:0]})
	                          : {1'b0, top[TB-1:0]};

	// shared multiplier: |end-start| * i, later amplitude * |cos|
	assign mul_a = (state_q == S_SCALE) ? MA'(amp_q) : MA'(d_q);
	assign mul_b = (state_q == S_SCALE) ? MB'(tv_q) : MB'(i_q);
	assign prod  = mul_a * mul_b;

	// one restoring divide step
	assign trial     = {rem_q, quo_q[PB-1]};
	assign div_ge    = (trial >= {1'b0, m_q});
	assign trial_sub = trial - {1'b0, m_q};
	assign rem_nx    = div_ge ? trial_sub[IB-1:0] : trial[IB-1:0];

	// round half away from zero on the magnitude
	assign rnd = scl_q + SCL_W'(1 << 14);
	assign mag = rnd[SCL_W-1:15];

	always_ff @(posedge clk) begin
		tv_q <= COS_ROM[rom_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_inc_q <= START_INC_RST;
			end_inc_q   <= END_INC_RST;
			sweep_len_q <= SWEEP_LEN_RST;
			amp_q       <= AMP_W'(AMPLITUDE_RST);
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_START_INC: start_inc_q <= cfg_data[INC_W-1:0];
				REG_END_INC:   end_inc_q   <= cfg_data[INC_W-1:0];
				REG_SWEEP_LEN: sweep_len_q <= cfg_data[SWEEP_LEN_W-1:0];
				REG_AMPLITUDE: amp_q       <= cfg_data[AMP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= '0;
			idx_q       <= '0;
			prev_inc_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						phase_q     <= start_sweep ? e_inc : phase_q + prev_inc_q;
						idx_q       <= is_last ? '0 : idx_cur + IB'(1);
						i_q         <= is_last ? m_w : idx_cur;
						m_q         <= m_w;
						last_flag_q <= is_last;
						up_q        <= (e_inc >= s_inc);
						d_q         <= (e_inc >= s_inc) ? (e_inc - s_inc) : (s_inc - e_inc);
						state_q     <= S_MUL;
					end
				end
				S_MUL: begin
					// d*i < m * 2^PB, so the top IB bits already sit below m
					rem_q   <= prod[PB+IB-1:PB];
					quo_q   <= prod[PB-1:0];
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= rem_nx;
					quo_q <= {quo_q[PB-2:0], div_ge};
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(PB - 1)) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					prev_inc_q <= up_q ? (s_inc + quo_q) : (s_inc - quo_q);
					scl_q      <= prod[SCL_W-1:0];
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (load_out) begin
						sample_q <= (quad[1] ^ quad[0]) ? -$signed({1'b0, mag})
						                                : $signed({1'b0, mag});
						last_q   <= last_flag_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign last      = last_q;

	// an accepted item blocks the input until its result is loaded
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input accepted while an item is in flight");

	// divider partial remainder always stays below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < m_q))
		else $error("divider remainder out of range");

	// interpolated offset never exceeds the full span
	a_quo_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCALE) |-> (quo_q <= d_q))
		else $error("increment offset beyond span");

	// interpolation index never passes the last sample
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> (i_q <= m_q))
		else $error("sample index beyond sweep end");

endmodule
